>>> rtl/vvst_pkg.sv
package vvst_pkg;

  // Field widths of the request and result items
  localparam int COORD_W = 8;
  localparam int HEAD_W  = 16;

  // Configuration register widths
  localparam int VW_W    = 16;
  localparam int RANGE_W = 7;
  localparam int SIZE_W  = 9;
  localparam int R2_W    = 2 * RANGE_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Bearing resolution, units per turn = 2**ANGLE_BITS
  localparam int ANGLE_BITS_DEF = 16;

  // CORDIC datapath: offsets scaled by 2**FRAC, angle in 2**-32 turn
  localparam int CORDIC_STEPS = 28;
  localparam int FRAC         = 30;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int XY_W         = COORD_W + FRAC + 4;
  localparam int Z_W          = 32;
  localparam int SQ_W         = 2 * COORD_W;
  localparam int DIST_W       = SQ_W + 2;

  localparam logic [Z_W-1:0] HALF_TURN = 32'h8000_0000;

  localparam logic [Z_W-1:0] ARC_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIEW_WIDTH  = 3'd0,
    REG_SENSE_RANGE = 3'd1,
    REG_SIZE_X      = 3'd2,
    REG_SIZE_Y      = 3'd3,
    REG_SIZE_Z      = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [COORD_W-1:0]       sensor_x;
    logic [COORD_W-1:0]       sensor_y;
    logic [COORD_W-1:0]       sensor_z;
    logic signed [HEAD_W-1:0] heading;
    logic [COORD_W-1:0]       cell_x;
    logic [COORD_W-1:0]       cell_y;
    logic [COORD_W-1:0]       cell_z;
    logic                     map_free;
  } vvst_req_t;

  typedef struct packed {
    logic seen_free;
    logic outside_space;
  } vvst_rsp_t;

  // Control that travels alongside the CORDIC pipe
  typedef struct packed {
    logic                     valid;
    logic                     own;
    logic                     outside;
    logic                     ok;
    logic                     vert;
    logic signed [HEAD_W-1:0] heading;
  } vvst_side_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [Z_W-1:0]         z;
  } vvst_cord_t;

  // Arithmetic shift right, rounding toward zero
  function automatic logic signed [XY_W-1:0] shr_tz(input logic signed [XY_W-1:0] v,
                                                    input int unsigned s);
    logic signed [XY_W-1:0] bias;
    bias = v[XY_W-1] ? ((XY_W'(1) << s) - XY_W'(1)) : '0;
    return (v + bias) >>> s;
  endfunction

endpackage

>>> rtl/voxel_view_sector_test_top.sv
// Voxel view sector test: per voxel, decide whether the sensor sees it free.
// Request: raise start with req_i for one cycle; a request is taken at every
// clock edge where start is high and busy is low. busy stays low, so one
// request can enter in every cycle and the full rate is one voxel per cycle.
// Result: rsp_o is shown for exactly one cycle with valid_o high, in request
// order. The pipe registers the offsets and the workspace test, then the
// squares, then each CORDIC vectoring step in its own register, then the
// heading offset and last the sector compare.
// The receiver cannot hold results off, and nothing waits on it.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 view width, 1 sensing range, kept squared, 2..4 extents x, y, z).
// Write only while no request is in flight. Unknown indexes are ignored.
// Reset: clears all pipe valid bits, drops requests in flight and restores
// view width 21845, range 5 and extents 5.
module voxel_view_sector_test_top
  import vvst_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  vvst_req_t             req_i,
  output logic                  valid_o,
  output vvst_rsp_t             rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int LATENCY = CORDIC_STEPS + 4;
  localparam int CMP_W   = (ANGLE_BITS + 1 > VW_W) ? ANGLE_BITS + 1 : VW_W;
  localparam logic [Z_W-1:0] ROUND = Z_W'(1) << (31 - ANGLE_BITS);

  typedef struct packed {
    logic                     valid;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
    logic                     outside;
    logic                     map_free;
    logic signed [HEAD_W-1:0] heading;
  } ofs_t;

  typedef struct packed {
    logic                     valid;
    logic                     own;
    logic                     outside;
    logic                     map_free;
    logic                     vert;
    logic signed [HEAD_W-1:0] heading;
    logic [SQ_W-1:0]          sq_x;
    logic [SQ_W-1:0]          sq_y;
    logic [SQ_W-1:0]          sq_z;
  } sq_t;

  typedef struct packed {
    logic                  valid;
    logic                  own;
    logic                  outside;
    logic                  ok;
    logic [ANGLE_BITS-1:0] diff;
  } ang_t;

  // Configuration
  logic [VW_W-1:0]   view_width_q;
  logic [R2_W-1:0]   range2_q;
  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
  logic [RANGE_W-1:0] range_wr;

  assign range_wr = cfg_wdata_i[RANGE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_width_q <= VW_W'(21845);
      range2_q     <= R2_W'(25);
      size_x_q     <= SIZE_W'(5);
      size_y_q     <= SIZE_W'(5);
      size_z_q     <= SIZE_W'(5);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_VIEW_WIDTH:  view_width_q <= cfg_wdata_i[VW_W-1:0];
        REG_SENSE_RANGE: range2_q     <= R2_W'(range_wr) * R2_W'(range_wr);
        REG_SIZE_X:      size_x_q     <= cfg_wdata_i[SIZE_W-1:0];
        REG_SIZE_Y:      size_y_q     <= cfg_wdata_i[SIZE_W-1:0];
        REG_SIZE_Z:      size_z_q     <= cfg_wdata_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage 1: offsets and workspace test
  ofs_t ofs_d, ofs_q;

  always_comb begin
    ofs_d.valid    = start && !busy;
    ofs_d.dx       = $signed({1'b0, req_i.cell_x}) - $signed({1'b0, req_i.sensor_x});
    ofs_d.dy       = $signed({1'b0, req_i.cell_y}) - $signed({1'b0, req_i.sensor_y});
    ofs_d.dz       = $signed({1'b0, req_i.cell_z}) - $signed({1'b0, req_i.sensor_z});
    ofs_d.outside  = !(SIZE_W'(req_i.cell_x) < size_x_q &&
                       SIZE_W'(req_i.cell_y) < size_y_q &&
                       SIZE_W'(req_i.cell_z) < size_z_q);
    ofs_d.map_free = req_i.map_free;
    ofs_d.heading  = req_i.heading;
  end

  // Stage 2: squares and CORDIC start vector
  sq_t        sq_d, sq_q;
  vvst_cord_t cinit_d, cinit_q;
  logic signed [DIFF_W-1:0] ax, ay;
  logic signed [2*DIFF_W-1:0] px, py, pz;

  always_comb begin
    px = ofs_q.dx * ofs_q.dx;
    py = ofs_q.dy * ofs_q.dy;
    pz = ofs_q.dz * ofs_q.dz;
    sq_d.valid    = ofs_q.valid;
    sq_d.own      = (ofs_q.dx == '0) && (ofs_q.dy == '0) && (ofs_q.dz == '0);
    sq_d.vert     = (ofs_q.dx == '0) && (ofs_q.dy == '0);
    sq_d.outside  = ofs_q.outside;
    sq_d.map_free = ofs_q.map_free;
    sq_d.heading  = ofs_q.heading;
    sq_d.sq_x     = px[SQ_W-1:0];
    sq_d.sq_y     = py[SQ_W-1:0];
    sq_d.sq_z     = pz[SQ_W-1:0];
    // Fold a left-pointing vector into the right half plane
    ax = ofs_q.dx[DIFF_W-1] ? -ofs_q.dx : ofs_q.dx;
    ay = ofs_q.dx[DIFF_W-1] ? -ofs_q.dy : ofs_q.dy;
    cinit_d.x = {{(XY_W-DIFF_W){ax[DIFF_W-1]}}, ax} << FRAC;
    cinit_d.y = {{(XY_W-DIFF_W){ay[DIFF_W-1]}}, ay} << FRAC;
    cinit_d.z = ofs_q.dx[DIFF_W-1] ? HALF_TURN : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_q <= '0;
      sq_q  <= '0;
    end else begin
      ofs_q <= ofs_d;
      sq_q  <= sq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cinit_q <= cinit_d;
  end

  // Range test runs beside the first CORDIC step
  vvst_side_t side_in, side_out;
  vvst_cord_t cord_out;
  logic [DIST_W-1:0] dist2;

  always_comb begin
    dist2           = DIST_W'(sq_q.sq_x) + DIST_W'(sq_q.sq_y) + DIST_W'(sq_q.sq_z);
    side_in.valid   = sq_q.valid;
    side_in.own     = sq_q.own;
    side_in.outside = sq_q.outside;
    side_in.ok      = !sq_q.outside && sq_q.map_free && (dist2 <= DIST_W'(range2_q));
    side_in.vert    = sq_q.vert;
    side_in.heading = sq_q.heading;
  end

  vvst_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .side_i (side_in),
    .cord_i (cinit_q),
    .side_o (side_out),
    .cord_o (cord_out)
  );

  // Round the bearing and take its offset from the heading
  ang_t ang_d, ang_q;
  logic [Z_W-1:0]        z_rnd;
  logic [ANGLE_BITS-1:0] bearing;
  logic [2*HEAD_W-1:0]   head_ext;

  always_comb begin
    z_rnd         = cord_out.z + ROUND;
    bearing       = side_out.vert ? '0 : z_rnd[Z_W-1 -: ANGLE_BITS];
    head_ext      = {{HEAD_W{side_out.heading[HEAD_W-1]}}, side_out.heading};
    ang_d.valid   = side_out.valid;
    ang_d.own     = side_out.own;
    ang_d.outside = side_out.outside;
    ang_d.ok      = side_out.ok;
    ang_d.diff    = bearing - head_ext[ANGLE_BITS-1:0];
  end

  // Sector compare and result register
  logic [ANGLE_BITS-1:0] mag;
  logic [ANGLE_BITS:0]   mag2;
  logic                  in_sector;
  vvst_rsp_t             rsp_d, rsp_q;
  logic                  valid_q;

  always_comb begin
    mag             = ang_q.diff[ANGLE_BITS-1] ? -ang_q.diff : ang_q.diff;
    mag2            = {mag, 1'b0};
    in_sector       = CMP_W'(mag2) <= CMP_W'(view_width_q);
    rsp_d.seen_free = ang_q.own || (ang_q.ok && in_sector);
    rsp_d.outside_space = ang_q.outside;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      ang_q   <= ang_d;
      valid_q <= ang_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  // Every taken request comes out as a valid result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY valid_o)
    else $error("request lost in pipe");

  // The sensor cell is always reported free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ang_q.valid && ang_q.own) |=> (valid_o && rsp_o.seen_free))
    else $error("own cell not reported free");

  // A free voxel outside the workspace can only be the sensor cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ang_q.valid && !ang_q.own && ang_q.outside) |=> !rsp_o.seen_free)
    else $error("voxel outside workspace reported free");

endmodule

>>> rtl/vvst_cordic.sv
module vvst_cordic
  import vvst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  vvst_side_t side_i,
  input  vvst_cord_t cord_i,
  output vvst_side_t side_o,
  output vvst_cord_t cord_o
);

  vvst_side_t side_q [CORDIC_STEPS];
  vvst_cord_t cord_q [CORDIC_STEPS];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    vvst_side_t side_in;
    vvst_cord_t cord_in;
    vvst_cord_t cord_d;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic                   y_pos;

    if (k == 0) begin : g_first
      assign side_in = side_i;
      assign cord_in = cord_i;
    end else begin : g_next
      assign side_in = side_q[k-1];
      assign cord_in = cord_q[k-1];
    end

    assign xs    = shr_tz(cord_in.x, k);
    assign ys    = shr_tz(cord_in.y, k);
    assign y_pos = !cord_in.y[XY_W-1] && (cord_in.y != '0);

    // Rotate toward the x axis, accumulate the angle turned
    always_comb begin
      if (y_pos) begin
        cord_d.x = cord_in.x + ys;
        cord_d.y = cord_in.y - xs;
        cord_d.z = cord_in.z + ARC_TAB[k];
      end else begin
        cord_d.x = cord_in.x - ys;
        cord_d.y = cord_in.y + xs;
        cord_d.z = cord_in.z - ARC_TAB[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[k] <= '0;
      end else begin
        side_q[k] <= side_in;
      end
    end

    always_ff @(posedge clk_i) begin
      cord_q[k] <= cord_d;
    end
  end

  assign side_o = side_q[CORDIC_STEPS-1];
  assign cord_o = cord_q[CORDIC_STEPS-1];

endmodule
